/* rtl/core/pct_pkg.sv */
// Shared types, sizes and operation codes for the pair combination table.
// No dependencies; every other file of the block but pct_ram uses it.
package pct_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int TABLE_COUNT = 4;

    localparam int KEY_W   = 32;
    localparam int CODE_W  = 21;
    localparam int HALF_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int TABLE_ID_W = 3;
    localparam int ENTRY_W = KEY_W + CODE_W;

    // Index wide enough to hold a fill count up to TABLE_DEPTH inclusive.
    localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
    localparam int TID_W = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int RAM_DEPTH = TABLE_COUNT * TABLE_DEPTH;
    localparam int RAM_AW = $clog2(RAM_DEPTH);

    // One cell per halving step of the lower-bound search.
    localparam int SEARCH_STEPS = $clog2(TABLE_DEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } srch_tok_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } rd_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PROBE_RD,
        ST_PROBE,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/pct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/pct_search_cell.sv */
// One halving step of the lower-bound search: reads the midpoint, narrows lo/hi.
// Depends on pct_pkg.
module pct_search_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pct_pkg::srch_tok_t            tok_in,
    input  logic [pct_pkg::KEY_W-1:0]     key,
    input  logic [pct_pkg::KEY_W-1:0]     rd_key,
    output pct_pkg::rd_req_t              rd_req,
    output pct_pkg::srch_tok_t            tok_out
);

    logic                        wait_reg;
    logic                        wait_next;
    logic [pct_pkg::IDX_W-1:0]   lo_reg;
    logic [pct_pkg::IDX_W-1:0]   hi_reg;
    logic [pct_pkg::IDX_W-1:0]   mid_reg;
    logic [pct_pkg::IDX_W:0]     mid_sum;
    logic [pct_pkg::IDX_W-1:0]   mid;
    pct_pkg::srch_tok_t          tok_out_reg;
    pct_pkg::srch_tok_t          tok_out_next;

    assign mid_sum = {1'b0, tok_in.lo} + {1'b0, tok_in.hi};
    assign mid     = mid_sum[pct_pkg::IDX_W:1];

    always_comb
    begin
        rd_req.valid = tok_in.valid && (tok_in.lo < tok_in.hi);
        rd_req.idx   = mid;
        wait_next    = rd_req.valid;

        tok_out_next       = tok_in;
        tok_out_next.valid = 1'b0;
        if (wait_reg)
        begin
            tok_out_next.valid = 1'b1;
            if (rd_key < key)
            begin
                tok_out_next.lo = mid_reg + 1'b1;
                tok_out_next.hi = hi_reg;
            end
            else
            begin
                tok_out_next.lo = lo_reg;
                tok_out_next.hi = mid_reg;
            end
        end
        else if (tok_in.valid && !rd_req.valid)
        begin
            // range already empty: pass straight on
            tok_out_next.valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg    <= 1'b0;
            tok_out_reg <= '0;
        end
        else
        begin
            wait_reg    <= wait_next;
            tok_out_reg <= tok_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.valid)
        begin
            lo_reg  <= tok_in.lo;
            hi_reg  <= tok_in.hi;
            mid_reg <= mid;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

/* rtl/core/pair_combination_table_top.sv */
// Top level of the pair combination table: sorted tables in one RAM, a chain of
// search cells for lower-bound lookup, and the insert/lookup/clear sequencer.
// Depends on pct_pkg, pct_ram, pct_search_cell.
//
//   channel | valid     | stall     | words
//   --------+-----------+-----------+-----------------------------------------------
//   input   | in_valid  | in_stall  | func, table_id, first_code, second_code,
//           |           |           | result_in
//   output  | out_valid | out_stall | result_out, found, accepted
//
// One word is worked on at a time; in_stall is high from accept until the result
// has moved into the output register. Clear, bad table id and unused func go from
// accept straight to the final step. Lookup walks the chain of SEARCH_STEPS cells,
// each reading the RAM at its midpoint unless its range is already empty, then
// reads the entry at the found position as a probe. Insert does the same search and
// probe; unless the key is already there or the table is full, it then moves each
// entry from the position up one slot, top first, and writes the new entry into
// the opened slot, all through the single RAM read and write port. A stalled output
// word holds the next result in the final step until the output register frees up.
// The stored entries need no reset: only entries below a table's count are ever
// read. Reset clears the counts and handshakes.
module pair_combination_table_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pct_pkg::FUNC_W-1:0]       func,
    input  logic [pct_pkg::TABLE_ID_W-1:0]   table_id,
    input  logic [pct_pkg::HALF_W-1:0]       first_code,
    input  logic [pct_pkg::HALF_W-1:0]       second_code,
    input  logic [pct_pkg::CODE_W-1:0]       result_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pct_pkg::CODE_W-1:0]       result_out,
    output logic                             found,
    output logic                             accepted
);

    localparam int LAST = pct_pkg::SEARCH_STEPS;

    pct_pkg::state_t                state_reg, state_next;

    // captured word
    logic [pct_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [pct_pkg::TID_W-1:0]      tid_reg, tid_next;
    logic [pct_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [pct_pkg::CODE_W-1:0]     code_reg, code_next;
    logic [pct_pkg::RAM_AW-1:0]     base_reg, base_next;
    logic [pct_pkg::IDX_W-1:0]      n_reg, n_next;

    // search / shift bookkeeping
    logic [pct_pkg::IDX_W-1:0]      pos_reg, pos_next;
    logic [pct_pkg::IDX_W-1:0]      src_reg, src_next;
    logic [pct_pkg::IDX_W-1:0]      remain_reg, remain_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [pct_pkg::IDX_W-1:0]      pend_addr_reg, pend_addr_next;

    // per-table fill counts
    logic [pct_pkg::IDX_W-1:0]      count_reg [pct_pkg::TABLE_COUNT];
    logic [pct_pkg::IDX_W-1:0]      count_next [pct_pkg::TABLE_COUNT];

    // pending result and output register
    logic [pct_pkg::CODE_W-1:0]     res_reg, res_next;
    logic                           fnd_reg, fnd_next;
    logic                           acc_reg, acc_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pct_pkg::CODE_W-1:0]     out_res_reg, out_res_next;
    logic                           out_fnd_reg, out_fnd_next;
    logic                           out_acc_reg, out_acc_next;

    pct_pkg::srch_tok_t             launch_reg, launch_next;
    pct_pkg::srch_tok_t             tok_chain [LAST+1];
    pct_pkg::rd_req_t               cell_req [LAST];
    logic                           srch_rd;
    logic [pct_pkg::IDX_W-1:0]      srch_idx;

    // RAM port
    logic                           ram_wr_en;
    logic [pct_pkg::RAM_AW-1:0]     ram_wr_addr;
    logic [pct_pkg::ENTRY_W-1:0]    ram_wr_data;
    logic                           ram_rd_en;
    logic [pct_pkg::RAM_AW-1:0]     ram_rd_addr;
    logic [pct_pkg::ENTRY_W-1:0]    ram_rd_data;
    logic [pct_pkg::KEY_W-1:0]      rd_key;
    logic [pct_pkg::CODE_W-1:0]     rd_code;

    logic                           tid_ok;
    logic [pct_pkg::TID_W-1:0]      tid_idx;
    logic                           hit;

    assign rd_key  = ram_rd_data[pct_pkg::ENTRY_W-1:pct_pkg::CODE_W];
    assign rd_code = ram_rd_data[pct_pkg::CODE_W-1:0];
    assign tid_ok  = (4'(table_id) < 4'(pct_pkg::TABLE_COUNT));
    assign tid_idx = table_id[pct_pkg::TID_W-1:0];
    assign hit     = (pos_reg < n_reg) && (rd_key == key_reg);

    pct_ram #(
        .WIDTH (pct_pkg::ENTRY_W),
        .DEPTH (pct_pkg::RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Search chain: the token hops cell to cell, each cell narrowing [lo, hi).
    assign tok_chain[0] = launch_reg;

    for (genvar c = 0; c < LAST; c++)
    begin : g_cell
        pct_search_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[c]),
            .key     (key_reg),
            .rd_key  (rd_key),
            .rd_req  (cell_req[c]),
            .tok_out (tok_chain[c+1])
        );
    end

    // At most one cell reads at a time, so the requests merge by OR.
    always_comb
    begin
        srch_rd  = 1'b0;
        srch_idx = '0;
        for (int c = 0; c < LAST; c++)
        begin
            srch_rd  = srch_rd | cell_req[c].valid;
            srch_idx = srch_idx | (cell_req[c].valid ? cell_req[c].idx : '0);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        tid_next        = tid_reg;
        key_next        = key_reg;
        code_next       = code_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        pos_next        = pos_reg;
        src_next        = src_reg;
        remain_next     = remain_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        fnd_next        = fnd_reg;
        acc_next        = acc_reg;
        launch_next     = launch_reg;
        launch_next.valid = 1'b0;

        out_valid_next  = out_valid_reg && out_stall;
        out_res_next    = out_res_reg;
        out_fnd_next    = out_fnd_reg;
        out_acc_next    = out_acc_reg;

        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        in_stall        = 1'b1;

        unique case (state_reg)
            pct_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    func_next = func;
                    tid_next  = tid_idx;
                    key_next  = {first_code, second_code};
                    code_next = result_in;
                    base_next = pct_pkg::RAM_AW'(table_id)
                                * pct_pkg::RAM_AW'(pct_pkg::TABLE_DEPTH);
                    n_next    = tid_ok ? count_reg[tid_idx] : '0;
                    res_next  = '0;
                    fnd_next  = 1'b0;
                    acc_next  = 1'b0;
                    state_next = pct_pkg::ST_DONE;
                    if (tid_ok)
                    begin
                        unique case (func) inside
                            pct_pkg::FUNC_INSERT,
                            pct_pkg::FUNC_LOOKUP:
                            begin
                                launch_next.valid = 1'b1;
                                launch_next.lo    = '0;
                                launch_next.hi    = count_reg[tid_idx];
                                state_next        = pct_pkg::ST_SEARCH;
                            end
                            pct_pkg::FUNC_CLEAR:
                            begin
                                count_next[tid_idx] = '0;
                                acc_next            = 1'b1;
                            end
                            default:
                            begin
                                // unused code: all-zero result
                            end
                        endcase
                    end
                end
            end

            pct_pkg::ST_SEARCH:
            begin
                ram_rd_en   = srch_rd;
                ram_rd_addr = base_reg + pct_pkg::RAM_AW'(srch_idx);
                if (tok_chain[LAST].valid)
                begin
                    pos_next   = tok_chain[LAST].lo;
                    state_next = pct_pkg::ST_PROBE_RD;
                end
            end

            pct_pkg::ST_PROBE_RD:
            begin
                ram_rd_en   = (pos_reg < n_reg);
                ram_rd_addr = base_reg + pct_pkg::RAM_AW'(pos_reg);
                state_next  = pct_pkg::ST_PROBE;
            end

            pct_pkg::ST_PROBE:
            begin
                state_next = pct_pkg::ST_DONE;
                if (func_reg == pct_pkg::FUNC_LOOKUP)
                begin
                    res_next = hit ? rd_code : '0;
                    fnd_next = hit;
                end
                else if (!hit && (n_reg != pct_pkg::IDX_W'(pct_pkg::TABLE_DEPTH)))
                begin
                    remain_next     = n_reg - pos_reg;
                    src_next        = n_reg - 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = pct_pkg::ST_SHIFT;
                end
            end

            pct_pkg::ST_SHIFT:
            begin
                // read entry src, write it one slot up on the next cycle
                if (pend_valid_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = base_reg + pct_pkg::RAM_AW'(pend_addr_reg);
                    ram_wr_data = ram_rd_data;
                end
                if (remain_reg != '0)
                begin
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = base_reg + pct_pkg::RAM_AW'(src_reg);
                    pend_valid_next = 1'b1;
                    pend_addr_next  = src_reg + 1'b1;
                    src_next        = src_reg - 1'b1;
                    remain_next     = remain_reg - 1'b1;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = base_reg + pct_pkg::RAM_AW'(pos_reg);
                        ram_wr_data         = {key_reg, code_reg};
                        count_next[tid_reg] = n_reg + 1'b1;
                        acc_next            = 1'b1;
                        state_next          = pct_pkg::ST_DONE;
                    end
                end
            end

            pct_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_fnd_next   = fnd_reg;
                    out_acc_next   = acc_reg;
                    state_next     = pct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pct_pkg::ST_IDLE;
            launch_reg       <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int t = 0; t < pct_pkg::TABLE_COUNT; t++)
            begin
                count_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            launch_reg       <= launch_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        tid_reg       <= tid_next;
        key_reg       <= key_next;
        code_reg      <= code_next;
        base_reg      <= base_next;
        n_reg         <= n_next;
        pos_reg       <= pos_next;
        src_reg       <= src_next;
        remain_reg    <= remain_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
        fnd_reg       <= fnd_next;
        acc_reg       <= acc_next;
        out_res_reg   <= out_res_next;
        out_fnd_reg   <= out_fnd_next;
        out_acc_reg   <= out_acc_next;
    end

    assign out_valid  = out_valid_reg;
    assign result_out = out_res_reg;
    assign found      = out_fnd_reg;
    assign accepted   = out_acc_reg;

endmodule

/* rtl/core/pct_checker.sv */
// Port-level checks for the pair combination table, bound to the top level.
// Depends on pct_pkg and pair_combination_table_top.
module pct_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [pct_pkg::CODE_W-1:0]       result_out,
    input  logic                             found,
    input  logic                             accepted
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_out)
                                   && $stable(found) && $stable(accepted))
        else $error("output word changed while stalled");

    // one word at a time: the block stalls right after taking a word
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in work");

    // a lookup hit never also reports a table change
    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && accepted))
        else $error("found and accepted both set");

    // a miss or non-lookup word carries a zero code
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> result_out == '0)
        else $error("nonzero code without a hit");

    // a new result only shows up while the input side is held off
    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no word in work");

endmodule

bind pair_combination_table_top pct_checker u_pct_checker (.*);

/* tb/sv/pct_result_check.sv */
// Result checker for the pair combination table: tracks accepted words, predicts
// the reply of each one from its own copy of the tables, and compares replies.
// Depends on pct_pkg for widths, sizes and operation codes.
module pct_result_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [pct_pkg::FUNC_W-1:0]       func,
    input  logic [pct_pkg::TABLE_ID_W-1:0]   table_id,
    input  logic [pct_pkg::HALF_W-1:0]       first_code,
    input  logic [pct_pkg::HALF_W-1:0]       second_code,
    input  logic [pct_pkg::CODE_W-1:0]       result_in,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [pct_pkg::CODE_W-1:0]       result_out,
    input  logic                             found,
    input  logic                             accepted,
    output int                               fail_count,
    output int                               words_due,
    output int                               checked_count,
    output int                               hit_count,
    output int                               refused_count
);
    import pct_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              hit;
        logic              took;
    } reply_t;

    // Own copy of the tables, kept sorted by key within the filled part.
    logic [KEY_W-1:0]  key_mem  [TABLE_COUNT][TABLE_DEPTH];
    logic [CODE_W-1:0] code_mem [TABLE_COUNT][TABLE_DEPTH];
    int                fill     [TABLE_COUNT];
    reply_t            due_replies [$];

    int errors;
    int words_checked;
    int hits;
    int refusals;

    function automatic reply_t apply_table_op(
        input logic [FUNC_W-1:0]     op,
        input logic [TABLE_ID_W-1:0] tid,
        input logic [HALF_W-1:0]     hi_code,
        input logic [HALF_W-1:0]     lo_code,
        input logic [CODE_W-1:0]     code
    );
        reply_t           r;
        logic [KEY_W-1:0] key;
        int               t;
        int               n;
        int               pos;
        int               i;
        r   = '0;
        key = {hi_code, lo_code};
        t   = int'(tid);
        if (t < TABLE_COUNT)
        begin
            n   = fill[t];
            pos = 0;
            while (pos < n && key_mem[t][pos] < key)
                pos++;
            case (op)
                FUNC_INSERT:
                begin
                    if ((pos == n || key_mem[t][pos] != key) && n < TABLE_DEPTH)
                    begin
                        for (i = n; i > pos; i--)
                        begin
                            key_mem[t][i]  = key_mem[t][i-1];
                            code_mem[t][i] = code_mem[t][i-1];
                        end
                        key_mem[t][pos]  = key;
                        code_mem[t][pos] = code;
                        fill[t]          = n + 1;
                        r.took           = 1'b1;
                    end
                    else
                        refusals++;
                end
                FUNC_LOOKUP:
                begin
                    if (pos < n && key_mem[t][pos] == key)
                    begin
                        r.code = code_mem[t][pos];
                        r.hit  = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    fill[t] = 0;
                    r.took  = 1'b1;
                end
                default: ;
            endcase
        end
        else if (op == FUNC_INSERT)
            refusals++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int t = 0; t < TABLE_COUNT; t++)
                fill[t] = 0;
            due_replies.delete();
            errors        = 0;
            words_checked = 0;
            hits          = 0;
            refusals      = 0;
            fail_count    <= 0;
            words_due     <= 0;
            checked_count <= 0;
            hit_count     <= 0;
            refused_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_replies.size() == 0)
                begin
                    $display("%0t: result word with none due: result_out %h found %b accepted %b",
                             $time, result_out, found, accepted);
                    errors++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    words_checked++;
                    if (want.hit)
                        hits++;
                    if (result_out !== want.code)
                    begin
                        $display("%0t: result_out mismatch: expected %h, actual %h",
                                 $time, want.code, result_out);
                        errors++;
                    end
                    if (found !== want.hit)
                    begin
                        $display("%0t: found mismatch: expected %b, actual %b",
                                 $time, want.hit, found);
                        errors++;
                    end
                    if (accepted !== want.took)
                    begin
                        $display("%0t: accepted mismatch: expected %b, actual %b",
                                 $time, want.took, accepted);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                due_replies.push_back(apply_table_op(func, table_id, first_code,
                                                     second_code, result_in));
            fail_count    <= errors;
            words_due     <= due_replies.size();
            checked_count <= words_checked;
            hit_count     <= hits;
            refused_count <= refusals;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the pair combination table testbench: clock, reset, word stimulus and
// output back-pressure, plus the verdict. Depends on pct_pkg, the block top and
// pct_result_check, which does all prediction and comparison.
module tb_top;
    import pct_pkg::*;

    // func value outside the three defined operations; the block must ignore it
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam logic [CODE_W-1:0] MAX_CODE   = 21'h10FFFF;

    localparam int RANDOM_WORDS = 600;
    localparam int KEY_POOL     = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    // Fill keys: entry index in the top bits, random below, so they ascend.
    localparam int FILL_SHIFT   = KEY_W - $clog2(TABLE_DEPTH);
    // Worst case is roughly 1200 words, the slowest an insert with a full shift,
    // plus stalls; about 5.6M time units. Allow 3-4x that.
    localparam int TIME_LIMIT   = 20_000_000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [FUNC_W-1:0]     func        = FUNC_LOOKUP;
    logic [TABLE_ID_W-1:0] table_id    = '0;
    logic [HALF_W-1:0]     first_code  = '0;
    logic [HALF_W-1:0]     second_code = '0;
    logic [CODE_W-1:0]     result_in   = '0;
    logic                  out_stall   = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [CODE_W-1:0]     result_out;
    logic                  found;
    logic                  accepted;

    int fail_count;
    int words_due;
    int checked_count;
    int hit_count;
    int refused_count;

    // sender burst state
    int burst_left = 0;

    // receiver state: one long hold-off on request, else a changing stall pattern
    logic hold_req     = 1'b0;
    bit   hold_used    = 1'b0;
    int   hold_left    = 0;
    int   pattern_left = 0;
    int   stall_mode   = 0;

    logic [KEY_W-1:0] key_pool  [KEY_POOL];
    logic [KEY_W-1:0] fill_keys [TABLE_DEPTH];

    always #4 clk = ~clk;

    pair_combination_table_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .table_id    (table_id),
        .first_code  (first_code),
        .second_code (second_code),
        .result_in   (result_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_out  (result_out),
        .found       (found),
        .accepted    (accepted)
    );

    pct_result_check table_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .table_id      (table_id),
        .first_code    (first_code),
        .second_code   (second_code),
        .result_in     (result_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_out    (result_out),
        .found         (found),
        .accepted      (accepted),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .checked_count (checked_count),
        .hit_count     (hit_count),
        .refused_count (refused_count)
    );

    // Offer one word and return at the edge that takes it. Words come in bursts;
    // between bursts valid usually drops, sometimes not at all.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_word(
        input logic [FUNC_W-1:0]     op,
        input logic [TABLE_ID_W-1:0] tid,
        input logic [KEY_W-1:0]      key,
        input logic [CODE_W-1:0]     code
    );
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        func        <= op;
        table_id    <= tid;
        first_code  <= key[KEY_W-1:HALF_W];
        second_code <= key[HALF_W-1:0];
        result_in   <= code;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
    endtask

    // Mostly pooled keys on the four real tables so inserts collide and lookups
    // hit; the rest is fresh keys, bad table ids, clears and the spare func.
    task automatic send_random_word();
        int                    roll;
        logic [FUNC_W-1:0]     op;
        logic [TABLE_ID_W-1:0] tid;
        logic [KEY_W-1:0]      key;
        roll = $urandom_range(0, 99);
        if (roll < 46)
            op = FUNC_INSERT;
        else if (roll < 88)
            op = FUNC_LOOKUP;
        else if (roll < 93)
            op = FUNC_CLEAR;
        else
            op = FUNC_SPARE;
        if ($urandom_range(0, 9) < 9)
            tid = TABLE_ID_W'($urandom_range(0, TABLE_COUNT - 1));
        else
            tid = TABLE_ID_W'($urandom_range(TABLE_COUNT, 7));
        if ($urandom_range(0, 9) < 7)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else
            key = $urandom;
        send_word(op, tid, key, CODE_W'($urandom_range(0, MAX_CODE)));
    endtask

    // Receiver. Normally picks a stall pattern (none, light, heavy, alternate)
    // and keeps it for a random stretch. Once, on request from the stimulus, it
    // holds off for HOLD_CYCLES so the block backs up and stalls its input.
    always @(posedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (pattern_left == 0)
        begin
            stall_mode   = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 160);
        end
        pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        // corner keys: all zero, all one, and each half saturated alone
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h0000_FFFF;
        key_pool[3] = 32'hFFFF_0000;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty lookup, extreme keys and codes, duplicate insert,
        // miss next to a hit, table isolation, bad ids for every op, spare func,
        // clear then re-insert over a stale entry.
        send_word(FUNC_LOOKUP, 0, 32'h0000_0000, MAX_CODE);
        send_word(FUNC_INSERT, 0, 32'h0000_0000, MAX_CODE);
        send_word(FUNC_INSERT, 0, 32'hFFFF_FFFF, '0);
        send_word(FUNC_INSERT, 0, 32'h1234_5678, 21'h0ABCDE);
        send_word(FUNC_INSERT, 0, 32'h0000_0000, 21'h000005);
        send_word(FUNC_LOOKUP, 0, 32'h0000_0000, '0);
        send_word(FUNC_LOOKUP, 0, 32'hFFFF_FFFF, MAX_CODE);
        send_word(FUNC_LOOKUP, 0, 32'h1234_5678, '0);
        send_word(FUNC_LOOKUP, 0, 32'h1234_5679, '0);
        send_word(FUNC_LOOKUP, 1, 32'h0000_0000, '0);
        send_word(FUNC_INSERT, 3, 32'hFFFF_0000, 21'h155555);
        send_word(FUNC_LOOKUP, 3, 32'hFFFF_0000, '0);
        send_word(FUNC_INSERT, 4, 32'h0000_0001, 21'h000001);
        send_word(FUNC_LOOKUP, 7, 32'h0000_0000, '0);
        send_word(FUNC_CLEAR,  5, 32'hFFFF_FFFF, MAX_CODE);
        send_word(FUNC_SPARE,  0, 32'h0000_0000, MAX_CODE);
        send_word(FUNC_CLEAR,  0, 32'h0000_0000, '0);
        send_word(FUNC_LOOKUP, 0, 32'h0000_0000, '0);
        send_word(FUNC_INSERT, 0, 32'h0000_0000, 21'h000007);
        send_word(FUNC_LOOKUP, 0, 32'h0000_0000, '0);
        send_word(FUNC_CLEAR,  3, 32'h0000_0000, '0);
        send_word(FUNC_INSERT, 2, 32'hAAAA_5555, 21'h0AAAAA);
        send_word(FUNC_LOOKUP, 2, 32'hAAAA_5555, '0);

        // Random mix; partway in, ask the receiver for its long hold-off.
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 5)
                hold_req <= 1'b1;
            send_random_word();
        end

        // Fill table 1 to the brim. The first eight go in descending order to
        // force slot shifts; the rest ascend so each insert lands at the end.
        for (i = 0; i < TABLE_DEPTH; i++)
            fill_keys[i] = (KEY_W'(i) << FILL_SHIFT) |
                           ($urandom & ((KEY_W'(1) << FILL_SHIFT) - 1));
        send_word(FUNC_CLEAR, 1, $urandom, '0);
        for (i = 7; i >= 0; i--)
            send_word(FUNC_INSERT, 1, fill_keys[i], CODE_W'($urandom_range(0, MAX_CODE)));
        for (i = 8; i < TABLE_DEPTH; i++)
            send_word(FUNC_INSERT, 1, fill_keys[i], CODE_W'($urandom_range(0, MAX_CODE)));
        // full table: fresh keys and a duplicate are all refused
        for (i = 0; i < 3; i++)
            send_word(FUNC_INSERT, 1, $urandom, CODE_W'($urandom_range(0, MAX_CODE)));
        send_word(FUNC_INSERT, 1, fill_keys[TABLE_DEPTH/2], MAX_CODE);
        // lookups over the full table: both ends, random picks, likely misses
        send_word(FUNC_LOOKUP, 1, fill_keys[0], '0);
        send_word(FUNC_LOOKUP, 1, fill_keys[TABLE_DEPTH-1], '0);
        for (i = 0; i < 20; i++)
            send_word(FUNC_LOOKUP, 1, fill_keys[$urandom_range(0, TABLE_DEPTH - 1)], '0);
        send_word(FUNC_LOOKUP, 1, $urandom, '0);
        send_word(FUNC_LOOKUP, 1, fill_keys[3] ^ 32'h1, '0);
        // after a clear the old entries must be gone, and inserts work again
        send_word(FUNC_CLEAR,  1, '0, '0);
        send_word(FUNC_LOOKUP, 1, fill_keys[0], '0);
        send_word(FUNC_INSERT, 1, fill_keys[0], 21'h000123);
        send_word(FUNC_LOOKUP, 1, fill_keys[0], '0);

        // Drain: the count of due words is registered, so step first.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d result words: %0d lookup hits, %0d refused inserts,",
                 checked_count, hit_count, refused_count);
        $display("bad table ids, the spare func, clears, and a table filled to %0d entries.",
                 TABLE_DEPTH);
        if (fail_count == 0 && words_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog in case the handshake locks up.
    initial
    begin
        #(TIME_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule
